>>> hdl/tlds_pkg.sv
// Package for the top-level delimiter scanner: sizes, character codes,
// register indexes, shared types and small helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlds_pkg;

    // Sizes of the scanner.
    localparam int MAX_OPENER_LENGTH = 8;
    localparam int DEPTH_BITS        = 8;
    localparam int POSITION_BITS     = 16;
    localparam int OFFSET_BITS       = 16;
    localparam int BYTE_BITS         = 8;
    localparam int OPENER_BITS       = 64;
    localparam int LENGTH_BITS       = 4;
    localparam int CFG_INDEX_BITS    = 4;

    // Reset values of the configuration registers.
    localparam logic [OPENER_BITS-1:0] OPENER_BYTES_RESET  = 64'd58;
    localparam logic [LENGTH_BITS-1:0] OPENER_LENGTH_RESET = 4'd1;

    // Character codes.
    localparam logic [BYTE_BITS-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_BITS-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_BITS-1:0] CH_LPAREN    = 8'h28;
    localparam logic [BYTE_BITS-1:0] CH_RPAREN    = 8'h29;
    localparam logic [BYTE_BITS-1:0] CH_LBRACK    = 8'h5B;
    localparam logic [BYTE_BITS-1:0] CH_RBRACK    = 8'h5D;
    localparam logic [BYTE_BITS-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_BITS-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_BITS-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_BITS-1:0] CH_CR        = 8'h0D;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OPENER_BYTES  = 4'd0,
        CFG_OPENER_LENGTH = 4'd1
    } t_cfg_index;

    typedef logic [BYTE_BITS-1:0]     t_byte;
    typedef logic [DEPTH_BITS-1:0]    t_depth;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [OFFSET_BITS-1:0]   t_offset;

    // The most recent bytes, element 0 being the newest.
    typedef t_byte [MAX_OPENER_LENGTH-1:0] t_window;

    localparam t_depth DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam t_pos   POS_MAX   = {POSITION_BITS{1'b1}};

    // Space, tab, LF, VT, FF or CR.
    function automatic logic is_white(input t_byte b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    // Saturating depth increment.
    function automatic t_depth depth_inc(input t_depth d);
        return (d == DEPTH_MAX) ? d : d + t_depth'(1);
    endfunction

    // Clip a position to the width of an output offset.
    function automatic t_offset sat_offset(input t_pos v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? {OFFSET_BITS{1'b1}} : w[OFFSET_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/tlds_match.sv
// Opener comparator: checks the window of recent bytes against the opener
// for the configured length. Depends on tlds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlds_match
    import tlds_pkg::*;
(
    input  wire t_window                      i_window,
    input  wire logic [MAX_OPENER_LENGTH-1:0] i_history,
    input  wire logic [OPENER_BITS-1:0]       i_opener_bytes,
    input  wire logic [LENGTH_BITS-1:0]       i_opener_length,
    output logic                              o_match
);

    logic [MAX_OPENER_LENGTH-1:0] eq_len;

    // For every possible length, compare the window with the opener. The
    // first opener character lines up with the oldest byte of the candidate.
    always_comb begin
        for (int l = 0; l < MAX_OPENER_LENGTH; l++) begin
            eq_len[l] = 1'b1;
            for (int i = 0; i <= l; i++) begin
                if (i_window[l-i] != i_opener_bytes[BYTE_BITS*i +: BYTE_BITS]) begin
                    eq_len[l] = 1'b0;
                end
            end
        end
    end

    // Pick the configured length; a length of zero or beyond the window
    // selects nothing and so never matches.
    always_comb begin
        o_match = 1'b0;
        for (int l = 0; l < MAX_OPENER_LENGTH; l++) begin
            if ((i_opener_length == LENGTH_BITS'(l + 1)) && i_history[l] && eq_len[l]) begin
                o_match = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/top_level_delimiter_scanner.sv
// Top level of the delimiter scanner: input register, per-line scan state,
// result register and configuration registers. Depends on tlds_pkg, tlds_match.
//
//  Channel   Direction  Handshake                Payload
//  input     in         i_valid / o_stall        i_text_byte, i_line_end
//  result    out        o_valid / i_stall        o_found, o_opener_offset,
//                                                o_body_offset, o_line_too_long
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One byte is taken every cycle unless the input stalls. A byte is registered on
// entry and scanned from the input register; when a line end moves on, the
// result of its line is loaded into the output register and offered from there.
// The only stall is a line end meeting a result that has not yet been taken.
// Reset clears the scan state and loads the default opener (a colon, length one).
// Configuration writes are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module top_level_delimiter_scanner
    import tlds_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Byte input
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [BYTE_BITS-1:0]      i_text_byte,
    input  wire logic                      i_line_end,
    // Result output
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic                           o_found,
    output logic [OFFSET_BITS-1:0]         o_opener_offset,
    output logic [OFFSET_BITS-1:0]         o_body_offset,
    output logic                           o_line_too_long,
    // Configuration
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [OPENER_BITS-1:0]    i_cfg_data
);

    // Configuration registers
    logic [OPENER_BITS-1:0] r_opener_bytes;
    logic [LENGTH_BITS-1:0] r_opener_length;

    // Input register
    logic  r_in_valid;
    t_byte r_byte;
    logic  r_last;

    // Per-line scan state
    t_depth                       r_paren, n_paren;
    t_depth                       r_bracket, n_bracket;
    t_depth                       r_brace, n_brace;
    logic                         r_in_string, n_in_string;
    logic                         r_escape, n_escape;
    logic                         r_nonblank, n_nonblank;
    t_pos                         r_byte_pos, n_byte_pos;
    t_window                      r_recent, n_recent;
    logic [MAX_OPENER_LENGTH-1:0] r_history, n_history;
    logic                         r_found, n_found;
    t_pos                         r_match_start, n_match_start;
    t_pos                         r_body_pos, n_body_pos;
    logic                         r_settled, n_settled;
    logic                         r_overflow, n_overflow;

    // Result register
    logic    r_out_valid;
    logic    r_out_found;
    t_offset r_out_opener;
    t_offset r_out_body;
    logic    r_out_long;

    logic                         out_free;
    logic                         advance;
    logic                         accept;
    logic                         overflow_now;
    logic                         top;
    logic                         plain;
    logic                         allowed;
    t_window                      shift_window;
    logic [MAX_OPENER_LENGTH-1:0] shift_history;
    logic                         opener_match;
    logic                         res_found;
    t_offset                      res_opener;
    t_offset                      res_body;
    logic                         res_long;

    // Handshake: the registered byte moves on unless it ends a line and the
    // result register holds a word that is stalled and not yet taken.
    assign out_free    = !r_out_valid || !i_stall;
    assign advance     = r_in_valid && (!r_last || out_free);
    assign o_stall     = r_in_valid && !advance;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opener_bytes  <= OPENER_BYTES_RESET;
            r_opener_length <= OPENER_LENGTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_OPENER_BYTES) begin
                r_opener_bytes <= i_cfg_data;
            end
            if (i_cfg_index == CFG_OPENER_LENGTH) begin
                r_opener_length <= i_cfg_data[LENGTH_BITS-1:0];
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_text_byte;
            r_last <= i_line_end;
        end
    end

    // Window and start history with the current byte shifted in.
    always_comb begin
        top = !r_in_string && (r_paren == '0) && (r_bracket == '0) && (r_brace == '0);
        plain = (r_byte != CH_QUOTE) && (r_byte != CH_LPAREN) &&
                (r_byte != CH_LBRACK) && (r_byte != CH_LBRACE);
        allowed = top && plain && r_nonblank;
        shift_window[0]  = r_byte;
        shift_history[0] = allowed;
        for (int k = 1; k < MAX_OPENER_LENGTH; k++) begin
            shift_window[k]  = r_recent[k-1];
            shift_history[k] = r_history[k-1];
        end
    end

    tlds_match u_match (
        .i_window        (shift_window),
        .i_history       (shift_history),
        .i_opener_bytes  (r_opener_bytes),
        .i_opener_length (r_opener_length),
        .o_match         (opener_match)
    );

    // Next scan state for the registered byte.
    always_comb begin
        n_paren       = r_paren;
        n_bracket     = r_bracket;
        n_brace       = r_brace;
        n_in_string   = r_in_string;
        n_escape      = r_escape;
        n_nonblank    = r_nonblank;
        n_recent      = r_recent;
        n_history     = r_history;
        n_found       = r_found;
        n_match_start = r_match_start;
        n_body_pos    = r_body_pos;
        n_settled     = r_settled;

        overflow_now = r_overflow || (r_byte_pos == POS_MAX);
        n_overflow   = overflow_now;

        if (!r_found) begin
            // Quote and bracket tracking.
            if (r_in_string) begin
                if (r_escape) begin
                    n_escape = 1'b0;
                end else if (r_byte == CH_BACKSLASH) begin
                    n_escape = 1'b1;
                end else if (r_byte == CH_QUOTE) begin
                    n_in_string = 1'b0;
                end
            end else begin
                case (r_byte)
                    CH_QUOTE:  n_in_string = 1'b1;
                    CH_LPAREN: n_paren     = depth_inc(r_paren);
                    CH_RPAREN: n_paren     = (r_paren != '0) ? r_paren - t_depth'(1) : r_paren;
                    CH_LBRACK: n_bracket   = depth_inc(r_bracket);
                    CH_RBRACK: n_bracket   = (r_bracket != '0) ? r_bracket - t_depth'(1)
                                                                : r_bracket;
                    CH_LBRACE: n_brace     = depth_inc(r_brace);
                    CH_RBRACE: n_brace     = (r_brace != '0) ? r_brace - t_depth'(1) : r_brace;
                    default:   n_in_string = r_in_string;
                endcase
            end
            if ((r_byte != CH_SPACE) && (r_byte != CH_TAB)) begin
                n_nonblank = 1'b1;
            end
            n_recent  = shift_window;
            n_history = shift_history;

            // Record the first opener found at top level.
            if (!overflow_now && opener_match) begin
                n_found       = 1'b1;
                n_match_start = r_byte_pos - (POSITION_BITS'(r_opener_length) - t_pos'(1));
                n_body_pos    = (r_byte_pos == POS_MAX) ? POS_MAX : r_byte_pos + t_pos'(1);
                n_settled     = 1'b0;
            end
        end else if (!r_settled) begin
            // Count whitespace after the opener.
            if (is_white(r_byte)) begin
                if (r_body_pos != POS_MAX) begin
                    n_body_pos = r_body_pos + t_pos'(1);
                end
            end else begin
                n_settled = 1'b1;
            end
        end

        n_byte_pos = (r_byte_pos == POS_MAX) ? r_byte_pos : r_byte_pos + t_pos'(1);

        // Result of the line, taken before the state is cleared.
        res_found  = n_found;
        res_opener = n_found ? sat_offset(n_match_start) : '0;
        res_body   = n_found ? sat_offset(n_body_pos) : '0;
        res_long   = n_overflow;

        // A line end clears all per-line state.
        if (r_last) begin
            n_paren       = '0;
            n_bracket     = '0;
            n_brace       = '0;
            n_in_string   = 1'b0;
            n_escape      = 1'b0;
            n_nonblank    = 1'b0;
            n_byte_pos    = '0;
            n_recent      = '0;
            n_history     = '0;
            n_found       = 1'b0;
            n_match_start = '0;
            n_body_pos    = '0;
            n_settled     = 1'b0;
            n_overflow    = 1'b0;
        end
    end

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paren       <= '0;
            r_bracket     <= '0;
            r_brace       <= '0;
            r_in_string   <= 1'b0;
            r_escape      <= 1'b0;
            r_nonblank    <= 1'b0;
            r_byte_pos    <= '0;
            r_recent      <= '0;
            r_history     <= '0;
            r_found       <= 1'b0;
            r_match_start <= '0;
            r_body_pos    <= '0;
            r_settled     <= 1'b0;
            r_overflow    <= 1'b0;
        end else if (advance) begin
            r_paren       <= n_paren;
            r_bracket     <= n_bracket;
            r_brace       <= n_brace;
            r_in_string   <= n_in_string;
            r_escape      <= n_escape;
            r_nonblank    <= n_nonblank;
            r_byte_pos    <= n_byte_pos;
            r_recent      <= n_recent;
            r_history     <= n_history;
            r_found       <= n_found;
            r_match_start <= n_match_start;
            r_body_pos    <= n_body_pos;
            r_settled     <= n_settled;
            r_overflow    <= n_overflow;
        end
    end

    // Result register: loaded at a line end, emptied when the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out_found  <= res_found;
            r_out_opener <= res_opener;
            r_out_body   <= res_body;
            r_out_long   <= res_long;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_opener_offset = r_out_opener;
    assign o_body_offset   = r_out_body;
    assign o_line_too_long = r_out_long;

endmodule

`default_nettype wire
